[src/dual_wheel_speed_turn_controller_defines.svh]
// assertion macros shared by the checker of the wheel speed controller
`ifndef DUAL_WHEEL_SPEED_TURN_CONTROLLER_DEFINES_SVH
`define DUAL_WHEEL_SPEED_TURN_CONTROLLER_DEFINES_SVH

// antecedent in this cycle, consequent in the next one
`define DWST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define DWST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/dwst_pkg.sv]
// shared types and constants of the dual wheel speed and turn controller
package dwst_pkg;

  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;
  localparam int unsigned DRIVE_LIMIT_DEF      = 255;

  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 32;
  localparam int TGT_W      = 16;
  localparam int TURN_W     = 31;
  localparam int REQ_W      = 2;
  localparam int DRV_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CYCLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_DISTANCE = 1'b1;

  // power = (BIAS + K_TGT*target - K_SPD*speed) / DIV_C
  localparam int BIAS  = 20000;
  localparam int K_TGT = 35;
  localparam int K_SPD = 20;
  localparam int DIV_C = 1000;

  // speed magnitude is clamped to 2**SPD_CLAMP_EXP
  localparam int SPD_CLAMP_EXP = 40;
  localparam int NUM_W         = 48;
  // signed power before truncation to the drive width, covers drive limits up to 65535
  localparam int PWR_W         = 17;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic mul;
    logic div_step;
    logic num;
    logic scale;
    logic wr_out;
    logic wr_zero;
  } dwst_cmd_t;

endpackage

[src/dwst_ctrl.sv]
// controller state machine: handshakes and sequencing of the datapath
module dwst_ctrl #(
  parameter int unsigned DIV_STEPS = 52
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [dwst_pkg::REQ_W-1:0] in_req_type,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output dwst_pkg::dwst_cmd_t      cmd
);
  import dwst_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_NUM   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              zres_r, zres_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    zres_nxt      = zres_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          zres_nxt    = (in_req_type != REQ_CYCLE);
          state_nxt   = (in_req_type == REQ_CYCLE) ? S_PREP : S_WR;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = STEP_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_NUM;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_NUM: begin
        cmd.num   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        // result register free, or emptied at this edge
        if (!out_valid_r || !out_stall) begin
          if (zres_r) begin
            cmd.wr_zero = 1'b1;
          end else begin
            cmd.wr_out = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      zres_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      zres_r      <= zres_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/dwst_datapath.sv]
// datapath: wheel deltas, speed multiply and divide, power scaling, result register
module dwst_datapath #(
  parameter int unsigned TICKS_PER_SECOND = 1000000,
  parameter int unsigned DRIVE_LIMIT      = 255,
  parameter int unsigned MAG_W            = 52
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dwst_pkg::dwst_cmd_t                 cmd,
  input  logic                                cfg_we,
  input  logic [dwst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [dwst_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [dwst_pkg::COUNT_W-1:0] in_wheel1_count,
  input  logic signed [dwst_pkg::COUNT_W-1:0] in_wheel2_count,
  input  logic [dwst_pkg::TIME_W-1:0]         in_timestamp,
  output logic signed [dwst_pkg::DRV_W-1:0]   out_motor1_drive,
  output logic signed [dwst_pkg::DRV_W-1:0]   out_motor2_drive,
  output logic                                out_turn_done,
  output logic                                out_zero_interval
);
  import dwst_pkg::*;

  localparam int TPS_W   = MAG_W - COUNT_W;
  localparam int SPD_W   = SPD_CLAMP_EXP + 1;
  localparam int RCP_N   = $clog2((DRIVE_LIMIT + 1) * DIV_C);
  localparam int RCP_K   = RCP_N + $clog2(DIV_C);
  localparam int RCP_M_W = RCP_K - $clog2(DIV_C) + 1;
  localparam int RCP_P_W = RCP_N + RCP_M_W;

  localparam logic [TPS_W-1:0]   TPS_V       = TPS_W'(TICKS_PER_SECOND);
  localparam logic [63:0]        SPD_CLAMP_V = 64'd1 << SPD_CLAMP_EXP;
  localparam logic [RCP_M_W-1:0] RCP_M       =
    RCP_M_W'(((64'd1 << RCP_K) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));
  localparam logic [NUM_W-1:0]   SAT_TH      = NUM_W'((DRIVE_LIMIT + 1) * DIV_C);
  localparam logic [PWR_W-2:0]   LIM_V       = (PWR_W-1)'(DRIVE_LIMIT);
  // wheel two runs mirrored: its speed and its drive are negated
  localparam logic [1:0]         LANE_FLIP   = 2'b10;

  logic [TGT_W-1:0]   target_r;
  logic [TURN_W-1:0]  turn_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [TIME_W-1:0]  time_in_r;
  logic [TIME_W-1:0]  dt_r;
  logic               zero_r;
  logic               done_r;
  logic               done_out_r;
  logic               zero_out_r;

  logic [COUNT_W-1:0] in_cnt   [2];
  logic [COUNT_W-1:0] cnt_in_r [2];
  logic [COUNT_W-1:0] start_r  [2];
  logic [COUNT_W-1:0] last_r   [2];
  logic               neg_r    [2];
  logic [COUNT_W-1:0] mag_r    [2];
  logic [MAG_W-1:0]   quo_r    [2];
  logic [COUNT_W-1:0] rem_r    [2];
  logic signed [NUM_W-1:0] num_r [2];
  logic               sign_r   [2];
  logic               sat_r    [2];
  logic [RCP_N-1:0]   am_r     [2];
  logic [DRV_W-1:0]   motor_r  [2];
  logic [COUNT_W-1:0] wdel     [2];

  logic [TIME_W-1:0]        dt_v;
  logic signed [COUNT_W+1:0] prog;

  assign in_cnt[0] = in_wheel1_count;
  assign in_cnt[1] = in_wheel2_count;

  assign dt_v = time_in_r - last_time_r;
  assign prog = $signed({{2{wdel[0][COUNT_W-1]}}, wdel[0]})
              - $signed({{2{wdel[1][COUNT_W-1]}}, wdel[1]});

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [COUNT_W-1:0]      dc;
    logic [COUNT_W-1:0]      dmag;
    logic [COUNT_W:0]        shifted;
    logic [COUNT_W:0]        diff;
    logic                    fits;
    logic [SPD_W-1:0]        qc;
    logic                    spd_neg;
    logic signed [SPD_W:0]   spd;
    logic signed [NUM_W-1:0] num_v;
    logic [NUM_W-1:0]        abs_num;
    logic [RCP_P_W-1:0]      rprod;
    logic [PWR_W-2:0]        qmag;
    logic [PWR_W-2:0]        pmag;
    logic [PWR_W-1:0]        pext;
    logic [PWR_W-1:0]        pv;

    always_comb begin
      dc      = cnt_in_r[g] - last_r[g];
      dmag    = dc[COUNT_W-1] ? (-dc) : dc;
      wdel[g] = cnt_in_r[g] - start_r[g];

      // restoring divide step, one quotient bit per cycle
      shifted = {rem_r[g], quo_r[g][MAG_W-1]};
      diff    = shifted - {1'b0, dt_r};
      fits    = (shifted >= {1'b0, dt_r});

      qc      = ({{(64-MAG_W){1'b0}}, quo_r[g]} > SPD_CLAMP_V) ? SPD_W'(SPD_CLAMP_V)
                                                                : SPD_W'(quo_r[g]);
      spd_neg = neg_r[g] ^ LANE_FLIP[g];
      if (zero_r) begin
        spd = '0;
      end else if (spd_neg) begin
        spd = -$signed({1'b0, qc});
      end else begin
        spd = $signed({1'b0, qc});
      end
      num_v   = NUM_W'(BIAS)
              + NUM_W'($signed({1'b0, target_r})) * NUM_W'(K_TGT)
              - NUM_W'(spd) * NUM_W'(K_SPD);

      abs_num = num_r[g][NUM_W-1] ? NUM_W'(-num_r[g]) : NUM_W'(num_r[g]);

      // divide by the constant through its reciprocal, exact below the saturation bound
      rprod   = RCP_P_W'(am_r[g]) * RCP_P_W'(RCP_M);
      qmag    = (PWR_W-1)'(rprod >> RCP_K);
      pmag    = sat_r[g] ? LIM_V : qmag;
      pext    = {1'b0, pmag};
      pv      = (sign_r[g] ^ LANE_FLIP[g]) ? (-pext) : pext;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        start_r[g] <= '0;
        last_r[g]  <= '0;
      end else if (cmd.load_in && (in_req_type == REQ_START)) begin
        start_r[g] <= in_cnt[g];
        last_r[g]  <= in_cnt[g];
      end else if (cmd.prep) begin
        last_r[g]  <= cnt_in_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load_in) begin
        cnt_in_r[g] <= in_cnt[g];
      end
      if (cmd.prep) begin
        neg_r[g] <= dc[COUNT_W-1];
        mag_r[g] <= dmag;
      end
      if (cmd.mul) begin
        quo_r[g] <= MAG_W'(mag_r[g]) * MAG_W'(TPS_V);
        rem_r[g] <= '0;
      end else if (cmd.div_step) begin
        quo_r[g] <= {quo_r[g][MAG_W-2:0], fits};
        rem_r[g] <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      end
      if (cmd.num) begin
        num_r[g] <= num_v;
      end
      if (cmd.scale) begin
        sign_r[g] <= num_r[g][NUM_W-1];
        sat_r[g]  <= (abs_num >= SAT_TH);
        am_r[g]   <= abs_num[RCP_N-1:0];
      end
      if (cmd.wr_out) begin
        motor_r[g] <= pv[DRV_W-1:0];
      end else if (cmd.wr_zero) begin
        motor_r[g] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      turn_r      <= '0;
      last_time_r <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_TARGET_SPEED)) begin
        target_r <= cfg_wdata[TGT_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_TURN_DISTANCE)) begin
        turn_r <= cfg_wdata[TURN_W-1:0];
      end
      if (cmd.load_in && (in_req_type == REQ_START)) begin
        last_time_r <= in_timestamp;
      end else if (cmd.prep) begin
        last_time_r <= time_in_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      time_in_r <= in_timestamp;
    end
    if (cmd.prep) begin
      dt_r   <= dt_v;
      zero_r <= (dt_v == '0);
      done_r <= (prog >= $signed({3'b000, turn_r}));
    end
    if (cmd.wr_out) begin
      done_out_r <= done_r;
      zero_out_r <= zero_r;
    end else if (cmd.wr_zero) begin
      done_out_r <= 1'b0;
      zero_out_r <= 1'b0;
    end
  end

  assign out_motor1_drive  = motor_r[0];
  assign out_motor2_drive  = motor_r[1];
  assign out_turn_done     = done_out_r;
  assign out_zero_interval = zero_out_r;

endmodule

[src/dual_wheel_speed_turn_controller.sv]
// top level of the dual wheel speed and turn controller
// Works on one transaction at a time. A control-cycle transaction runs through
// the prepare, multiply, divide, numerator, scale and write-back steps before its
// result is valid; the divide step is the restoring divider, which produces one
// quotient bit per cycle for both wheels side by side over the
// 32 + clog2(TICKS_PER_SECOND+1) bit speed product.
// Start, stop and unused request codes go straight to the write-back step and
// give a zero-drive result. The next transaction is accepted in the cycle after
// a result is written. The result sits in an output register, so the next
// transaction is accepted while an earlier result still waits under out_stall;
// it only waits before the write-back step. Configuration registers may be
// written whenever no transaction is in flight; there is no reset sweep.
module dual_wheel_speed_turn_controller #(
  parameter int unsigned TICKS_PER_SECOND = dwst_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned DRIVE_LIMIT      = dwst_pkg::DRIVE_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dwst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dwst_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [dwst_pkg::COUNT_W-1:0] in_wheel1_count,
  input  logic signed [dwst_pkg::COUNT_W-1:0] in_wheel2_count,
  input  logic [dwst_pkg::TIME_W-1:0]         in_timestamp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dwst_pkg::DRV_W-1:0]   out_motor1_drive,
  output logic signed [dwst_pkg::DRV_W-1:0]   out_motor2_drive,
  output logic                                out_turn_done,
  output logic                                out_zero_interval
);
  import dwst_pkg::*;

  localparam int unsigned MAG_W = COUNT_W + $clog2(TICKS_PER_SECOND + 1);

  dwst_cmd_t cmd;

  dwst_ctrl #(
    .DIV_STEPS (MAG_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  dwst_datapath #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .DRIVE_LIMIT      (DRIVE_LIMIT),
    .MAG_W            (MAG_W)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_wheel1_count   (in_wheel1_count),
    .in_wheel2_count   (in_wheel2_count),
    .in_timestamp      (in_timestamp),
    .out_motor1_drive  (out_motor1_drive),
    .out_motor2_drive  (out_motor2_drive),
    .out_turn_done     (out_turn_done),
    .out_zero_interval (out_zero_interval)
  );

endmodule

[src/dwst_checker.sv]
// port-level checker for the wheel speed controller and its bind
`include "dual_wheel_speed_turn_controller_defines.svh"

module dwst_checker #(
  parameter int unsigned DRIVE_LIMIT = dwst_pkg::DRIVE_LIMIT_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [dwst_pkg::DRV_W-1:0] out_motor1_drive,
  input logic signed [dwst_pkg::DRV_W-1:0] out_motor2_drive,
  input logic                              out_turn_done,
  input logic                              out_zero_interval
);

  // a result under stall stays put
  `DWST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_motor1_drive) && $stable(out_motor2_drive) && $stable(out_turn_done) && $stable(out_zero_interval), "result changed while stalled")

  // only one transaction in flight
  `DWST_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "input taken while busy")

  // zero interval means both speeds are zero, so the drives mirror each other
  `DWST_ASSERT_NOW(a_zero_dt_mirror, out_valid && out_zero_interval, (out_motor1_drive + out_motor2_drive) == 9'sd0, "drives not mirrored on zero interval")

  // saturation keeps the drives off the most negative code
  `DWST_ASSERT_NOW(a_drive_range, out_valid && (DRIVE_LIMIT <= 255), (out_motor1_drive != 9'h100) && (out_motor2_drive != 9'h100), "drive beyond limit")

endmodule

bind dual_wheel_speed_turn_controller dwst_checker #(
  .DRIVE_LIMIT (DRIVE_LIMIT)
) u_dwst_checker (.*);

[tb/sv/dual_wheel_speed_turn_controller_test.sv]
// self-checking testbench for the dual wheel speed and turn controller
module dual_wheel_speed_turn_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dwst_pkg::*;

  // request code with no defined meaning, behaves like stop
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 70;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_ITEMS   = 480;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [COUNT_W-1:0] c1;
    logic [COUNT_W-1:0] c2;
    logic [TIME_W-1:0]  ts;
  } wheel_req_t;

  typedef struct packed {
    logic [DRV_W-1:0] m1;
    logic [DRV_W-1:0] m2;
    logic             done;
    logic             zero_dt;
  } drive_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          in_req_type = '0;
  logic signed [COUNT_W-1:0] in_wheel1_count = '0;
  logic signed [COUNT_W-1:0] in_wheel2_count = '0;
  logic [TIME_W-1:0]         in_timestamp = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DRV_W-1:0]   out_motor1_drive;
  logic signed [DRV_W-1:0]   out_motor2_drive;
  logic                      out_turn_done;
  logic                      out_zero_interval;

  wheel_req_t    pending_reqs[$];
  drive_result_t expected_drives[$];
  wheel_req_t    live_req;

  // shadow copy of the registers and the latched counts and time
  logic [TGT_W-1:0]   tgt_speed_q = '0;
  logic [TURN_W-1:0]  turn_dist_q = '0;
  logic [COUNT_W-1:0] base1_q = '0;
  logic [COUNT_W-1:0] base2_q = '0;
  logic [COUNT_W-1:0] prev1_q = '0;
  logic [COUNT_W-1:0] prev2_q = '0;
  logic [TIME_W-1:0]  prev_ts_q = '0;

  int n_pushed = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_zero_dt = 0;
  int n_done = 0;
  int n_saturated = 0;
  int n_settings = 0;
  int src_idle_pct = 27;
  int sink_idle_pct = 27;
  int sink_hold = 0;
  int cycle_cnt = 0;

  dual_wheel_speed_turn_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_wheel1_count   (in_wheel1_count),
    .in_wheel2_count   (in_wheel2_count),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_motor1_drive  (out_motor1_drive),
    .out_motor2_drive  (out_motor2_drive),
    .out_turn_done     (out_turn_done),
    .out_zero_interval (out_zero_interval)
  );

  always #10 clk = ~clk;

  // signed difference of two counts, wrapped to 32 bits
  function automatic longint count_delta(logic [COUNT_W-1:0] now_c, logic [COUNT_W-1:0] was_c);
    int d;
    d = now_c - was_c;
    return longint'(d);
  endfunction

  function automatic longint wheel_rate(longint dc, logic [TIME_W-1:0] dt);
    longint lim;
    longint s;
    lim = longint'(1) <<< SPD_CLAMP_EXP;
    s = dc * longint'(TICKS_PER_SECOND_DEF) / longint'(dt);
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    return s;
  endfunction

  function automatic longint motor_power(longint spd);
    longint lim;
    longint p;
    lim = longint'(DRIVE_LIMIT_DEF);
    p = (longint'(BIAS) + longint'(K_TGT) * longint'(tgt_speed_q) - longint'(K_SPD) * spd)
        / longint'(DIV_C);
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p;
  endfunction

  // expected drive for one request, advancing the shadow state
  function automatic drive_result_t predict_drive(wheel_req_t r);
    drive_result_t res;
    logic [TIME_W-1:0] dt;
    longint s1;
    longint s2;
    longint p1;
    longint m2;
    longint progress;
    res = '0;
    case (r.req)
      REQ_START: begin
        base1_q = r.c1;
        base2_q = r.c2;
        prev1_q = r.c1;
        prev2_q = r.c2;
        prev_ts_q = r.ts;
      end
      REQ_CYCLE: begin
        dt = r.ts - prev_ts_q;
        s1 = 0;
        s2 = 0;
        if (dt == '0) begin
          res.zero_dt = 1'b1;
        end else begin
          s1 = wheel_rate(count_delta(r.c1, prev1_q), dt);
          s2 = -wheel_rate(count_delta(r.c2, prev2_q), dt);
        end
        p1 = motor_power(s1);
        m2 = -motor_power(s2);
        res.m1 = p1[DRV_W-1:0];
        res.m2 = m2[DRV_W-1:0];
        progress = count_delta(r.c1, base1_q) - count_delta(r.c2, base2_q);
        res.done = (progress >= longint'(turn_dist_q));
        prev1_q = r.c1;
        prev2_q = r.c2;
        prev_ts_q = r.ts;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // sender: one transaction per handshake, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_drives.push_back(predict_drive(live_req));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          live_req = pending_reqs.pop_front();
          in_req_type <= live_req.req;
          in_wheel1_count <= live_req.c1;
          in_wheel2_count <= live_req.c2;
          in_timestamp <= live_req.ts;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest expected drive
  always @(posedge clk) begin
    drive_result_t want;
    drive_result_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.m1 = out_motor1_drive;
        got.m2 = out_motor2_drive;
        got.done = out_turn_done;
        got.zero_dt = out_zero_interval;
        if (expected_drives.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected, expected none, actual m1=%0d m2=%0d",
                   $time, out_motor1_drive, out_motor2_drive);
        end else begin
          want = expected_drives.pop_front();
          n_checked++;
          check_field("motor1_drive", int'($signed(want.m1)), int'($signed(got.m1)));
          check_field("motor2_drive", int'($signed(want.m2)), int'($signed(got.m2)));
          check_field("turn_done", int'(want.done), int'(got.done));
          check_field("zero_interval", int'(want.zero_dt), int'(got.zero_dt));
          if (got.zero_dt) n_zero_dt++;
          if (got.done) n_done++;
          if ($signed(got.m1) == 255 || $signed(got.m1) == -255) n_saturated++;
        end
      end
      // long hold-off lets the block fill up and stall its input
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d results seen", $time, n_checked, n_pushed);
      $display("** dual_wheel_speed_turn_controller: FAILED **");
      $finish;
    end
  end

  task automatic push_item(logic [REQ_W-1:0] req, logic [COUNT_W-1:0] c1,
                           logic [COUNT_W-1:0] c2, logic [TIME_W-1:0] ts);
    wheel_req_t r;
    r.req = req;
    r.c1 = c1;
    r.c2 = c2;
    r.ts = ts;
    pending_reqs.push_back(r);
    n_pushed++;
  endtask

  // both registers, written only while nothing is in flight
  task automatic program_regs(logic [TGT_W-1:0] tgt, logic [TURN_W-1:0] turn_len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TARGET_SPEED;
    cfg_wdata <= CFG_DATA_W'(tgt);
    @(posedge clk);
    cfg_index <= CFG_TURN_DISTANCE;
    cfg_wdata <= turn_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt_speed_q = tgt;
    turn_dist_q = turn_len;
    n_settings++;
  endtask

  task automatic wait_drained();
    while (n_checked != n_pushed) @(posedge clk);
  endtask

  // start, a run of control cycles with plausible wheel motion, usually a stop
  task automatic push_turn(int n_cyc);
    logic [COUNT_W-1:0] c1;
    logic [COUNT_W-1:0] c2;
    logic [TIME_W-1:0]  ts;
    if ($urandom_range(3) == 0) begin
      c1 = $urandom;
      c2 = $urandom;
    end else begin
      c1 = COUNT_W'($urandom_range(4000)) - 32'd2000;
      c2 = COUNT_W'($urandom_range(4000)) - 32'd2000;
    end
    ts = $urandom;
    push_item(REQ_START, c1, c2, ts);
    for (int i = 0; i < n_cyc; i++) begin
      c1 = c1 + COUNT_W'($urandom_range(16)) - 32'd3;
      c2 = c2 - COUNT_W'($urandom_range(16)) + 32'd3;
      if ($urandom_range(29) == 0)
        ts = ts + $urandom;
      else if ($urandom_range(19) != 0)
        ts = ts + TIME_W'($urandom_range(300, 4000));
      push_item(REQ_CYCLE, c1, c2, ts);
    end
    if ($urandom_range(4) != 0)
      push_item(REQ_STOP, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(16'd1200, 31'd100);
    // control cycle before any start runs on the reset state
    push_item(REQ_CYCLE, 32'd100, -32'sd100, 32'd1000);
    push_item(REQ_STOP, 32'd7, 32'd7, 32'd5);
    push_item(REQ_SPARE, 32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF);
    push_item(REQ_START, 32'd1000, -32'sd1000, 32'd5000);
    push_item(REQ_CYCLE, 32'd1003, -32'sd1003, 32'd5000);
    push_item(REQ_CYCLE, 32'd1005, -32'sd1005, 32'd6000);
    push_item(REQ_CYCLE, 32'd990, -32'sd990, 32'd7000);
    push_item(REQ_SPARE, 32'd0, 32'd0, 32'd0);
    push_item(REQ_CYCLE, 32'd1000, -32'sd1000, 32'd8000);
    // full-scale count jumps, clamped speeds, then wrap across the sign boundary
    push_item(REQ_START, 32'd0, 32'd0, 32'd100);
    push_item(REQ_CYCLE, 32'h7FFFFFFF, 32'h80000000, 32'd101);
    push_item(REQ_CYCLE, 32'h80000000, 32'h7FFFFFFF, 32'd102);
    // timestamp wraps past zero
    push_item(REQ_START, -32'sd5, 32'd5, 32'hFFFFFFF0);
    push_item(REQ_CYCLE, 32'd0, 32'd0, 32'h10);
    push_item(REQ_CYCLE, 32'd3, -32'sd3, 32'hFFFFFFFF);
    // progress one below and then exactly at the turn distance
    push_item(REQ_START, 32'd0, 32'd0, 32'd0);
    push_item(REQ_CYCLE, 32'd50, -32'sd49, 32'd1000);
    push_item(REQ_CYCLE, 32'd50, -32'sd50, 32'd2000);
    push_item(REQ_STOP, 32'h7FFFFFFF, 32'h80000000, 32'd0);
    wait_drained();

    program_regs(16'hFFFF, 31'h7FFFFFFF);
    push_item(REQ_START, 32'd0, 32'd0, 32'd0);
    push_item(REQ_CYCLE, 32'd0, 32'd0, 32'd1);
    push_item(REQ_CYCLE, -32'sd1000, 32'd1000, 32'd2);
    push_item(REQ_CYCLE, 32'd2000000, -32'sd2000000, 32'd3);
    wait_drained();

    program_regs(16'd0, 31'd0);
    push_item(REQ_CYCLE, 32'd2000000, -32'sd2000000, 32'd3);
    push_item(REQ_STOP, 32'd0, 32'd0, 32'd0);
    wait_drained();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        1: program_regs(16'd0, 31'h7FFFFFFF);
        4: program_regs(16'hFFFF, 31'd0);
        default: program_regs(TGT_W'($urandom_range(300, 3000)),
                              TURN_W'($urandom_range(20, 600)));
      endcase
      src_idle_pct = (phase == 2) ? 0 : 27;
      sink_idle_pct = (phase == 2) ? 0 : 27;
      if (phase == 3) sink_hold = 400;
      base = n_pushed;
      while (n_pushed - base < RAND_ITEMS / RAND_PHASES) begin
        if ($urandom_range(99) < 85)
          push_turn($urandom_range(3, 25));
        else
          repeat ($urandom_range(1, 3))
            push_item(REQ_W'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests under %0d register settings, %0d mismatches",
             n_pushed, n_settings, n_errors);
    $display("seen %0d zero-interval results, %0d turn-done flags, %0d saturated drives",
             n_zero_dt, n_done, n_saturated);
    if (n_errors == 0 && expected_drives.size() == 0)
      $display("** dual_wheel_speed_turn_controller: PASSED **");
    else
      $display("** dual_wheel_speed_turn_controller: FAILED **");
    $finish;
  end

endmodule
